// File: rtl/core/smpd_pkg.sv
`timescale 1ns / 1ps

package smpd_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int MAX_CLASSES = 8;
    localparam int SCORE_BITS  = 16;

    // fixed widths of the word fields
    localparam int IN_CLASSES = 8;
    localparam int CLS_W      = 3;
    localparam int RC_W       = 6;
    localparam int PEAK_W     = 18;
    localparam int FW_W       = 7;
    localparam int CNT_W      = 4;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 2;

    localparam int COL_W  = $clog2(MAX_SIDE);
    localparam int ROW_W  = COL_W + 1;
    localparam int GW     = COL_W + 1;
    localparam int POS_W  = 2 * COL_W + 2;
    localparam int RAW_W  = SCORE_BITS - 1;
    localparam int SUM_W  = RAW_W + 11;
    localparam int QDEPTH = 4;
    localparam int QP_W   = $clog2(QDEPTH);

    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    localparam int W_CORNER = 77;
    localparam int W_EDGE   = 128;
    localparam int W_CENTER = 256;
    localparam int ROUND    = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_CLASS_COUNT    = 2'd2,
        REG_PEAK_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                         mode;
        logic signed [SCORE_BITS-1:0] score_class0;
        logic signed [SCORE_BITS-1:0] score_class1;
        logic signed [SCORE_BITS-1:0] score_class2;
        logic signed [SCORE_BITS-1:0] score_class3;
        logic signed [SCORE_BITS-1:0] score_class4;
        logic signed [SCORE_BITS-1:0] score_class5;
        logic signed [SCORE_BITS-1:0] score_class6;
        logic signed [SCORE_BITS-1:0] score_class7;
    } pixel_t;

    typedef struct packed {
        logic              found;
        logic [CLS_W-1:0]  winning_class;
        logic [PEAK_W-1:0] peak_score;
        logic [RC_W-1:0]   row_index;
        logic [RC_W-1:0]   column_index;
        logic              frame_last;
    } result_t;

    typedef struct packed {
        logic [GW-1:0]     width;
        logic [GW-1:0]     height;
        logic [CNT_W-1:0]  nclass;
        logic [PEAK_W-1:0] threshold;
    } geom_t;

    // result bookkeeping that rides along with each word
    typedef struct packed {
        logic             emit;
        logic [COL_W-1:0] q_row;
        logic [COL_W-1:0] q_col;
        logic             q_last;
    } tag_t;

    typedef logic [MAX_CLASSES-1:0][RAW_W-1:0]  raw_vec_t;
    typedef logic [MAX_CLASSES-1:0][PEAK_W-1:0] smooth_vec_t;

    typedef struct packed {
        raw_vec_t         raw;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        tag_t             tag;
    } item_t;

    typedef struct packed {
        smooth_vec_t      s;
        logic [ROW_W-1:0] srow;
        logic             srow_ok;
        logic [COL_W-1:0] scol;
        tag_t             tag;
    } sm_t;

    function automatic logic [GW-1:0] clamp_side(input logic [FW_W-1:0] v);
        if (v == '0)
            return GW'(1);
        else if (int'(v) > MAX_SIDE)
            return GW'(MAX_SIDE);
        else
            return GW'(v);
    endfunction

    function automatic logic [CNT_W-1:0] clamp_classes(input logic [CNT_W-1:0] v);
        if (v == '0)
            return CNT_W'(1);
        else if (int'(v) > MAX_CLASSES)
            return CNT_W'(MAX_CLASSES);
        else
            return v;
    endfunction

endpackage

// File: rtl/core/smpd_front.sv
`timescale 1ns / 1ps

module smpd_front
    import smpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  geom_t  geom,
    input  logic   restart,
    input  logic   take,
    input  pixel_t pixel,
    output item_t  item
);

    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [POS_W-1:0] pos_reg;
    logic [COL_W-1:0] qrow_reg;
    logic [COL_W-1:0] qcol_reg;

    logic [IN_CLASSES-1:0][SCORE_BITS-1:0] sc;
    logic                                  store;
    logic                                  emit;
    logic                                  q_last;
    logic [POS_W-1:0]                      emit_from;
    logic [GW-1:0]                         wm1;
    logic [GW-1:0]                         hm1;
    logic                                  col_wrap;
    logic                                  qcol_wrap;

    assign sc = {pixel.score_class7, pixel.score_class6, pixel.score_class5,
                 pixel.score_class4, pixel.score_class3, pixel.score_class2,
                 pixel.score_class1, pixel.score_class0};

    assign wm1       = geom.width - GW'(1);
    assign hm1       = geom.height - GW'(1);
    assign store     = row_reg < geom.height;
    assign emit_from = (POS_W'(geom.width) << 1) + POS_W'(2);
    assign emit      = pos_reg >= emit_from;
    assign q_last    = (qrow_reg == hm1[COL_W-1:0]) && (qcol_reg == wm1[COL_W-1:0]);
    assign col_wrap  = (GW'(col_reg) + GW'(1)) >= geom.width;
    assign qcol_wrap = qcol_reg == wm1[COL_W-1:0];

    always_comb
    begin
        for (int k = 0; k < MAX_CLASSES; k++)
        begin
            // drop negative scores, flush steps and anything past the frame
            if (store && !pixel.mode && !sc[k][SCORE_BITS-1])
                item.raw[k] = sc[k][RAW_W-1:0];
            else
                item.raw[k] = '0;
        end
        item.row        = row_reg;
        item.col        = col_reg;
        item.tag.emit   = emit;
        item.tag.q_row  = qrow_reg;
        item.tag.q_col  = qcol_reg;
        item.tag.q_last = q_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            pos_reg  <= '0;
            qrow_reg <= '0;
            qcol_reg <= '0;
        end
        else if (restart || (take && emit && q_last))
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            pos_reg  <= '0;
            qrow_reg <= '0;
            qcol_reg <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_reg + POS_W'(1);
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (qcol_wrap)
                begin
                    qcol_reg <= '0;
                    qrow_reg <= qrow_reg + COL_W'(1);
                end
                else
                begin
                    qcol_reg <= qcol_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

// File: rtl/core/smpd_queue.sv
`timescale 1ns / 1ps

module smpd_queue
    import smpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t din,
    input  logic  pop,
    output item_t dout,
    output logic  full,
    output logic  empty
);

    item_t             entry_reg [QDEPTH];
    logic [QP_W-1:0]   wr_reg;
    logic [QP_W-1:0]   rd_reg;
    logic [QP_W:0]     count_reg;

    assign full  = count_reg == (QP_W+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign dout  = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QP_W'(1);
            if (pop)
                rd_reg <= rd_reg + QP_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QP_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QP_W+1)'(1);
        end
    end

endmodule

// File: rtl/core/smpd_smooth.sv
`timescale 1ns / 1ps

module smpd_smooth
    import smpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  geom_t geom,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output sm_t   out_s
);

    typedef logic [MAX_CLASSES-1:0][SUM_W-1:0] sum_vec_t;

    raw_vec_t line_mem [2*MAX_SIDE];

    logic     a_valid_reg;
    item_t    a_item_reg;
    logic     b_valid_reg;
    item_t    b_item_reg;
    raw_vec_t up1_reg;
    raw_vec_t up2_reg;
    logic     c_valid_reg;
    item_t    c_item_reg;
    sum_vec_t c_va_reg;
    sum_vec_t c_vb_reg;
    sum_vec_t h1_va_reg;
    sum_vec_t h1_vb_reg;
    sum_vec_t h2_va_reg;
    logic     d_valid_reg;
    sm_t      d_reg;

    logic [COL_W:0] wr_addr;
    logic [COL_W:0] rd_addr;
    sum_vec_t       va;
    sum_vec_t       vb;
    logic [GW-1:0]  wm1;
    logic           use_left;
    logic           use_right;
    logic           in_frame;
    sm_t            d_next;

    // line banks alternate with row parity: row-2 sits where row is written
    assign wr_addr = {a_item_reg.row[0], a_item_reg.col};
    assign rd_addr = {~a_item_reg.row[0], a_item_reg.col};

    always_ff @(posedge clk)
    begin
        if (adv && a_valid_reg)
        begin
            up1_reg           <= line_mem[rd_addr];
            up2_reg           <= line_mem[wr_addr];
            line_mem[wr_addr] <= a_item_reg.raw;
        end
    end

    // vertical pass: corner/edge column weights and edge/center column weights
    always_comb
    begin
        logic [SUM_W-1:0] r0;
        logic [SUM_W-1:0] r1;
        logic [SUM_W-1:0] r2;
        for (int k = 0; k < MAX_CLASSES; k++)
        begin
            r0 = SUM_W'(b_item_reg.raw[k]);
            r1 = (b_item_reg.row >= ROW_W'(1)) ? SUM_W'(up1_reg[k]) : '0;
            r2 = (b_item_reg.row >= ROW_W'(2)) ? SUM_W'(up2_reg[k]) : '0;
            va[k] = (r0 + r2) * SUM_W'(W_CORNER) + r1 * SUM_W'(W_EDGE);
            vb[k] = (r0 + r2) * SUM_W'(W_EDGE) + r1 * SUM_W'(W_CENTER);
        end
    end

    // horizontal pass: the center column is the previous word
    assign wm1       = geom.width - GW'(1);
    assign use_right = c_item_reg.col != '0;
    assign use_left  = (c_item_reg.col >= COL_W'(2)) ||
                       ((c_item_reg.col == '0) && (geom.width >= GW'(2)));

    always_comb
    begin
        logic [SUM_W-1:0] tot;
        logic [SUM_W-1:0] sh;
        d_next.tag = c_item_reg.tag;
        if (c_item_reg.col == '0)
        begin
            d_next.srow    = c_item_reg.row - ROW_W'(2);
            d_next.srow_ok = c_item_reg.row >= ROW_W'(2);
            d_next.scol    = wm1[COL_W-1:0];
        end
        else
        begin
            d_next.srow    = c_item_reg.row - ROW_W'(1);
            d_next.srow_ok = c_item_reg.row >= ROW_W'(1);
            d_next.scol    = c_item_reg.col - COL_W'(1);
        end
        in_frame = d_next.srow_ok && (d_next.srow < geom.height);
        for (int k = 0; k < MAX_CLASSES; k++)
        begin
            tot = h1_vb_reg[k] + (use_left ? h2_va_reg[k] : '0) +
                  (use_right ? c_va_reg[k] : '0) + SUM_W'(ROUND);
            sh  = tot >> 8;
            if (!in_frame)
                d_next.s[k] = '0;
            else if (sh > SUM_W'(PEAK_MAX))
                d_next.s[k] = PEAK_MAX;
            else
                d_next.s[k] = sh[PEAK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= in_item;
            b_item_reg <= a_item_reg;
            c_item_reg <= b_item_reg;
            c_va_reg   <= va;
            c_vb_reg   <= vb;
            d_reg      <= d_next;
        end
        if (adv && c_valid_reg)
        begin
            h1_va_reg <= c_va_reg;
            h1_vb_reg <= c_vb_reg;
            h2_va_reg <= h1_va_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_s     = d_reg;

endmodule

// File: rtl/core/smpd_nms.sv
`timescale 1ns / 1ps

module smpd_nms
    import smpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  geom_t   geom,
    input  logic    in_valid,
    input  sm_t     in_s,
    output logic    out_valid,
    output result_t out_result
);

    typedef logic [2:0][MAX_CLASSES-1:0][PEAK_W-1:0] column_t;
    typedef logic [2:0][2:0][MAX_CLASSES-1:0][PEAK_W-1:0] window_t;

    smooth_vec_t line_mem [2*MAX_SIDE];

    logic        e_valid_reg;
    sm_t         e_reg;
    smooth_vec_t up1_reg;
    smooth_vec_t up2_reg;
    column_t     u1_reg;
    column_t     u2_reg;
    logic        f_valid_reg;
    window_t     f_win_reg;
    tag_t        f_tag_reg;
    logic        g_valid_reg;
    window_t     g_win_reg;
    tag_t        g_tag_reg;
    logic [CLS_W-1:0]  g_best_reg;
    logic [PEAK_W-1:0] g_score_reg;
    logic        h_valid_reg;
    logic        h_emit_reg;
    result_t     h_reg;

    logic [COL_W:0]    wr_addr;
    logic [COL_W:0]    rd_addr;
    column_t           u_cur;
    window_t           win_next;
    logic              use_left;
    logic              use_right;
    logic [CLS_W-1:0]  best;
    logic [PEAK_W-1:0] best_score;
    result_t           h_next;

    assign wr_addr = {in_s.srow[0], in_s.scol};
    assign rd_addr = {~in_s.srow[0], in_s.scol};

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            up1_reg           <= line_mem[rd_addr];
            up2_reg           <= line_mem[wr_addr];
            line_mem[wr_addr] <= in_s.s;
        end
    end

    // column of three smoothed rows, rows above the frame read as zero
    always_comb
    begin
        u_cur[2] = e_reg.s;
        u_cur[1] = (e_reg.srow_ok && (e_reg.srow >= ROW_W'(1))) ? up1_reg : '0;
        u_cur[0] = (e_reg.srow_ok && (e_reg.srow >= ROW_W'(2))) ? up2_reg : '0;
    end

    assign use_right = e_reg.scol != '0;
    assign use_left  = (e_reg.scol >= COL_W'(2)) ||
                       ((e_reg.scol == '0) && (geom.width >= GW'(2)));

    always_comb
    begin
        win_next[1] = u1_reg;
        win_next[0] = use_left ? u2_reg : '0;
        win_next[2] = use_right ? u_cur : '0;
    end

    // argmax over the classes in use, first index wins a tie
    always_comb
    begin
        best       = '0;
        best_score = f_win_reg[1][1][0];
        for (int k = 1; k < MAX_CLASSES; k++)
        begin
            if ((CNT_W'(k) < geom.nclass) && (f_win_reg[1][1][k] > best_score))
            begin
                best       = CLS_W'(k);
                best_score = f_win_reg[1][1][k];
            end
        end
    end

    always_comb
    begin
        logic [PEAK_W-1:0] nb;
        logic              is_peak;
        is_peak = g_score_reg > geom.threshold;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                nb = '0;
                for (int k = 0; k < MAX_CLASSES; k++)
                begin
                    if (CLS_W'(k) == g_best_reg)
                        nb = g_win_reg[c][r][k];
                end
                if (!((c == 1) && (r == 1)) && !(g_score_reg > nb))
                    is_peak = 1'b0;
            end
        end
        h_next.found         = is_peak;
        h_next.winning_class = g_best_reg;
        h_next.peak_score    = g_score_reg;
        h_next.row_index     = RC_W'(g_tag_reg.q_row);
        h_next.column_index  = RC_W'(g_tag_reg.q_col);
        h_next.frame_last    = g_tag_reg.q_last;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg       <= in_s;
            f_win_reg   <= win_next;
            f_tag_reg   <= e_reg.tag;
            g_win_reg   <= f_win_reg;
            g_tag_reg   <= f_tag_reg;
            g_best_reg  <= best;
            g_score_reg <= best_score;
            h_emit_reg  <= g_tag_reg.emit;
            h_reg       <= h_next;
        end
        if (adv && e_valid_reg)
        begin
            u1_reg <= u_cur;
            u2_reg <= u1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    assign out_valid  = h_valid_reg && h_emit_reg;
    assign out_result = h_reg;

endmodule

// File: rtl/core/smpd_outq.sv
`timescale 1ns / 1ps

module smpd_outq
    import smpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t din,
    input  logic    pop,
    output result_t dout,
    output logic    full,
    output logic    empty
);

    result_t         entry_reg [QDEPTH];
    logic [QP_W-1:0] wr_reg;
    logic [QP_W-1:0] rd_reg;
    logic [QP_W:0]   count_reg;

    assign full  = count_reg == (QP_W+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign dout  = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QP_W'(1);
            if (pop)
                rd_reg <= rd_reg + QP_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QP_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QP_W+1)'(1);
        end
    end

endmodule

// File: rtl/core/score_map_peak_detector_top.sv
`timescale 1ns / 1ps
// channel   | handshake          | word
// ----------+--------------------+---------------------------------------
// pixel in  | push / full        | pixel  (mode, eight signed scores)
// result    | empty / pop        | result (found, class, score, row, col, last)
// config    | cfg_write          | cfg_index, cfg_data
//
// One pixel word per cycle while full is low; a result follows the word that
// completes its window, through a four-entry queue on each side.
// Reset clears counters, valid flags and queues; line memories need no clear.
// A full result queue stalls the whole back pipeline; the input queue then
// fills and raises full.

module score_map_peak_detector_top
    import smpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pixel_t               pixel,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [FW_W-1:0]   frame_width_reg;
    logic [FW_W-1:0]   frame_height_reg;
    logic [CNT_W-1:0]  class_count_reg;
    logic [PEAK_W-1:0] peak_threshold_reg;

    geom_t   geom;
    logic    restart;
    logic    take;
    item_t   front_item;
    item_t   q_item;
    logic    q_empty;
    logic    adv;
    logic    oq_full;
    logic    sm_valid;
    sm_t     sm;
    logic    nms_valid;
    result_t nms_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FW_W'(64);
            frame_height_reg   <= FW_W'(64);
            class_count_reg    <= CNT_W'(8);
            peak_threshold_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[FW_W-1:0];
                REG_CLASS_COUNT:    class_count_reg    <= cfg_data[CNT_W-1:0];
                REG_PEAK_THRESHOLD: peak_threshold_reg <= cfg_data[PEAK_W-1:0];
                default:            ;
            endcase
        end
    end

    // geometry writes restart the frame
    assign restart = cfg_write && (cfg_index_t'(cfg_index) != REG_PEAK_THRESHOLD);

    assign geom.width     = clamp_side(frame_width_reg);
    assign geom.height    = clamp_side(frame_height_reg);
    assign geom.nclass    = clamp_classes(class_count_reg);
    assign geom.threshold = peak_threshold_reg;

    assign take = push && !full;
    assign adv  = !oq_full;

    smpd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .restart (restart),
        .take    (take),
        .pixel   (pixel),
        .item    (front_item)
    );

    smpd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .din   (front_item),
        .pop   (adv && !q_empty),
        .dout  (q_item),
        .full  (full),
        .empty (q_empty)
    );

    smpd_smooth u_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .geom      (geom),
        .in_valid  (!q_empty),
        .in_item   (q_item),
        .out_valid (sm_valid),
        .out_s     (sm)
    );

    smpd_nms u_nms (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .geom       (geom),
        .in_valid   (sm_valid),
        .in_s       (sm),
        .out_valid  (nms_valid),
        .out_result (nms_result)
    );

    smpd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (adv && nms_valid),
        .din   (nms_result),
        .pop   (pop && !empty),
        .dout  (result),
        .full  (oq_full),
        .empty (empty)
    );

endmodule
